// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    // Width used for linear positions: wide enough for the store and the 11-bit field
    localparam int CALC_W  = (ADDR_W > 11) ? ADDR_W : 11;
    localparam int CELL_W  = 16;

    // Command modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_POKE  = 2'd2;
    localparam logic [1:0] MODE_PEEK  = 2'd3;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [7:0]        BLANK_CHAR = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam int                TAB_STEP   = 8;

    // Configuration register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [7:0] attr_in;
        logic [6:0] column;
        logic [4:0] row;
    } tcw_in_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } tcw_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_capture;
        logic copy_rd;
        logic copy_wr;
        logic fill;
        logic init;
        logic out_load;
    } tcw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       scroll;
        logic       copy_last;
        logic       fill_last;
    } tcw_status_t;

    // Linear cell position: row times COLUMNS plus column
    function automatic logic [CALC_W-1:0] cell_index(input logic [4:0] r, input logic [6:0] c);
        cell_index = CALC_W'(r) * CALC_W'(COLUMNS) + CALC_W'(c);
    endfunction

endpackage

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tcw_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: command latch, cursor, colour registers, sweep counter,
// screen store and result register.
// ----------------------------------------------------------------------------
module tcw_dp
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tcw_cmd_t    ctl,
    output tcw_status_t status,
    input  tcw_in_t     cmd,
    output tcw_out_t    rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    tcw_in_t             cmd_reg;
    logic [6:0]          cur_col_reg, cur_col_next;
    logic [4:0]          cur_row_reg, cur_row_next;
    logic [3:0]          fg_reg;
    logic [3:0]          bg_reg;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                scrolled_reg;
    logic [7:0]          rd_char_reg;
    logic [7:0]          rd_attr_reg;
    tcw_out_t            rsp_reg;

    logic [7:0]          cur_attr;
    logic [7:0]          col_ext, col_step, col_wrap;
    logic [5:0]          row_ext, row_step, row_wrap;
    logic                need_scroll;
    logic                put_wr;
    logic [7:0]          put_chr;
    logic [6:0]          put_col;
    logic                in_range;
    logic [CALC_W-1:0]   put_pos, pick_pos, cur_pos;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [CELL_W-1:0]   ram_wdata, ram_rdata;

    assign cur_attr = {bg_reg, fg_reg};

    // Work out the cursor move and the cell write for a put command
    always_comb
    begin
        col_ext  = {1'b0, cur_col_reg};
        row_ext  = {1'b0, cur_row_reg};
        col_step = col_ext;
        row_step = row_ext;
        put_wr   = 1'b0;
        put_chr  = cmd_reg.char_code;
        put_col  = cur_col_reg;
        case (cmd_reg.char_code)
            CH_NL:
            begin
                col_step = 8'd0;
                row_step = row_ext + 6'd1;
            end
            CH_CR:
            begin
                col_step = 8'd0;
            end
            CH_TAB:
            begin
                col_step = (col_ext + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
            end
            CH_BS:
            begin
                if (cur_col_reg != 7'd0)
                begin
                    col_step = col_ext - 8'd1;
                    put_wr   = 1'b1;
                    put_chr  = BLANK_CHAR;
                    put_col  = cur_col_reg - 7'd1;
                end
            end
            default:
            begin
                col_step = col_ext + 8'd1;
                put_wr   = 1'b1;
            end
        endcase

        // Wrap at the line end
        col_wrap = col_step;
        row_wrap = row_step;
        if (col_step >= 8'(COLUMNS))
        begin
            col_wrap = 8'd0;
            row_wrap = row_step + 6'd1;
        end
        need_scroll = (row_wrap >= 6'(ROWS));
    end

    assign in_range = ({1'b0, cmd_reg.column} < 8'(COLUMNS)) && ({1'b0, cmd_reg.row} < 6'(ROWS));
    assign put_pos  = cell_index(cur_row_reg, put_col);
    assign pick_pos = cell_index(cmd_reg.row, cmd_reg.column);
    assign cur_pos  = cell_index(cur_row_reg, cur_col_reg);

    // Store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = RESET_CELL;
        ram_raddr = ctl.copy_rd ? ADDR_W'(idx_reg + ADDR_W'(COLUMNS)) : pick_pos[ADDR_W-1:0];
        if (ctl.exec && (cmd_reg.mode == MODE_PUT))
        begin
            ram_we    = put_wr;
            ram_waddr = put_pos[ADDR_W-1:0];
            ram_wdata = {cur_attr, put_chr};
        end
        else if (ctl.exec && (cmd_reg.mode == MODE_POKE))
        begin
            ram_we    = in_range;
            ram_waddr = pick_pos[ADDR_W-1:0];
            ram_wdata = {cmd_reg.attr_in, cmd_reg.char_code};
        end
        else if (ctl.copy_wr)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (ctl.fill)
        begin
            ram_we    = 1'b1;
            ram_wdata = {cur_attr, BLANK_CHAR};
        end
        else if (ctl.init)
        begin
            ram_we    = 1'b1;
        end
    end

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Cursor and sweep counter next values
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        idx_next     = idx_reg;
        if (ctl.exec)
        begin
            if (cmd_reg.mode == MODE_PUT)
            begin
                cur_col_next = col_wrap[6:0];
                cur_row_next = need_scroll ? 5'(ROWS - 1) : row_wrap[4:0];
                idx_next     = '0;
            end
            else if (cmd_reg.mode == MODE_CLEAR)
            begin
                cur_col_next = 7'd0;
                cur_row_next = 5'd0;
                idx_next     = '0;
            end
        end
        else if (ctl.copy_wr || ctl.fill || ctl.init)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    // Control state: cursor, colours, sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            fg_reg      <= 4'd7;
            bg_reg      <= 4'd0;
            idx_reg     <= '0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            idx_reg     <= idx_next;
            if (cfg_we && (cfg_index == REG_FG))
            begin
                fg_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_BG))
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.exec)
        begin
            scrolled_reg <= (cmd_reg.mode == MODE_PUT) && need_scroll;
            rd_char_reg  <= 8'd0;
            rd_attr_reg  <= 8'd0;
        end
        if (ctl.rd_capture && in_range)
        begin
            rd_char_reg <= ram_rdata[7:0];
            rd_attr_reg <= ram_rdata[15:8];
        end
        if (ctl.out_load)
        begin
            rsp_reg.cursor_col <= cur_col_reg;
            rsp_reg.cursor_row <= cur_row_reg;
            rsp_reg.cursor_pos <= cur_pos[10:0];
            rsp_reg.scrolled   <= scrolled_reg;
            rsp_reg.cell_char  <= rd_char_reg;
            rsp_reg.cell_attr  <= rd_attr_reg;
        end
    end

    assign rsp              = rsp_reg;
    assign status.mode      = cmd_reg.mode;
    assign status.scroll    = need_scroll;
    assign status.copy_last = (idx_reg == ADDR_W'(CELLS - COLUMNS - 1));
    assign status.fill_last = (idx_reg == ADDR_W'(CELLS - 1));

endmodule

// ----- src/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences reset fill, command execution, scroll copy,
// screen fill and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  tcw_status_t status,
    output tcw_cmd_t    ctl
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_CPRD   = 3'd4;
    localparam logic [2:0] ST_CPWR   = 3'd5;
    localparam logic [2:0] ST_FILL   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.init = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                case (status.mode)
                    MODE_PUT:   state_next = status.scroll ? ST_CPRD : ST_DONE;
                    MODE_CLEAR: state_next = ST_FILL;
                    MODE_POKE:  state_next = ST_DONE;
                    MODE_PEEK:  state_next = ST_RDWAIT;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_RDWAIT:
            begin
                ctl.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_CPRD:
            begin
                ctl.copy_rd = 1'b1;
                state_next  = ST_CPWR;
            end
            ST_CPWR:
            begin
                ctl.copy_wr = 1'b1;
                state_next  = status.copy_last ? ST_FILL : ST_CPRD;
            end
            ST_FILL:
            begin
                ctl.fill = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        if (ctl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a character/attribute screen store and cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on cmd/cmd_valid and are taken when cmd_stall is low.
//   Each command yields one result beat on rsp/rsp_valid, held while
//   rsp_stall is high; the next command is taken while a result waits.
//   Colours are written on the cfg port (index 0 foreground, 1 background);
//   cfg_ready is always high, writes are meant for idle periods.
// Sequencing (from the accepting edge to the result beat):
//   put character, put cell: execute, then hand off; the next command is
//   taken after the hand-off. Read cell: execute, registered store read,
//   hand-off. A put that scrolls: one store read and one write per copied
//   cell. Clear screen: one cell written per cycle. A result blocked by
//   rsp_stall holds the next result back in turn, and cmd_stall stays high.
// Reset:
//   Cursor to 0,0, colours to 7 on 0, then a fill pass writes every cell
//   as a space on attribute 0x07 while cmd_stall stays high.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  tcw_in_t    cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output tcw_out_t   rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    tcw_cmd_t    ctl;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .ctl       (ctl)
    );

    tcw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- tb/sv/text_console_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. Commands are driven on the
// cmd channel with random gaps, and result beats are taken with random stalls.
// A mirror of the screen store, cursor and colours predicts every result.
// Directed commands hit the corner cases first, then random command sequences
// follow under several colour settings and idling patterns.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    // Mirror of the console: screen store, cursor, colours and awaited results
    class console_mirror;
        logic [CELL_W-1:0] cell_store [CELLS];
        int unsigned       caret_col;
        int unsigned       caret_row;
        logic [3:0]        fg;
        logic [3:0]        bg;
        tcw_out_t          awaited_reports [$];
        int                errors;

        function new();
            int i;
            for (i = 0; i < CELLS; i++)
                cell_store[i] = RESET_CELL;
            caret_col = 0;
            caret_row = 0;
            fg        = 4'd7;
            bg        = 4'd0;
            errors    = 0;
        endfunction

        function void set_colour(logic idx, logic [3:0] val);
            if (idx == REG_FG)
                fg = val;
            else
                bg = val;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // Advance the mirror by one accepted command beat and queue its result
        function void apply_command(tcw_in_t c);
            tcw_out_t    r;
            logic [7:0]  attr;
            bit          hit;
            int unsigned i;
            r    = '0;
            attr = {bg, fg};
            hit  = (int'(c.column) < COLUMNS) && (int'(c.row) < ROWS);
            case (c.mode)
                MODE_PUT:
                begin
                    if (c.char_code == CH_NL)
                    begin
                        caret_col = 0;
                        caret_row++;
                    end
                    else if (c.char_code == CH_CR)
                        caret_col = 0;
                    else if (c.char_code == CH_TAB)
                        caret_col = (caret_col / TAB_STEP + 1) * TAB_STEP;
                    else if (c.char_code == CH_BS)
                    begin
                        // backspace at column 0 leaves everything alone
                        if (caret_col > 0)
                        begin
                            caret_col--;
                            cell_store[caret_row * COLUMNS + caret_col] = {attr, BLANK_CHAR};
                        end
                    end
                    else
                    begin
                        cell_store[caret_row * COLUMNS + caret_col] = {attr, c.char_code};
                        caret_col++;
                    end
                    // wrap at the line end, scroll at the bottom
                    if (caret_col >= COLUMNS)
                    begin
                        caret_col = 0;
                        caret_row++;
                    end
                    if (caret_row >= ROWS)
                    begin
                        for (i = 0; i < CELLS - COLUMNS; i++)
                            cell_store[i] = cell_store[i + COLUMNS];
                        for (i = CELLS - COLUMNS; i < CELLS; i++)
                            cell_store[i] = {attr, BLANK_CHAR};
                        caret_row  = ROWS - 1;
                        r.scrolled = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    for (i = 0; i < CELLS; i++)
                        cell_store[i] = {attr, BLANK_CHAR};
                    caret_col = 0;
                    caret_row = 0;
                end
                MODE_POKE:
                begin
                    if (hit)
                        cell_store[c.row * COLUMNS + c.column] = {c.attr_in, c.char_code};
                end
                default:
                begin
                    if (hit)
                    begin
                        r.cell_char = cell_store[c.row * COLUMNS + c.column][7:0];
                        r.cell_attr = cell_store[c.row * COLUMNS + c.column][15:8];
                    end
                end
            endcase
            r.cursor_col = 7'(caret_col);
            r.cursor_row = 5'(caret_row);
            r.cursor_pos = 11'(caret_row * COLUMNS + caret_col);
            awaited_reports.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        // Match one result beat against the oldest awaited result
        function void check_result(tcw_out_t got);
            tcw_out_t want;
            if (awaited_reports.size() == 0)
            begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            want = awaited_reports.pop_front();
            compare_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
            compare_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            compare_field("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
            compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
            compare_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
            compare_field("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    tcw_in_t    cmd;
    logic       rsp_valid;
    logic       rsp_stall;
    tcw_out_t   rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [3:0] cfg_data;

    console_mirror mirror = new();
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;
    int            hold_left;
    int            sent_items;

    text_console_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest legal run (every command scrolling)
    initial
    begin
        #200_000_000;
        $display("text_console_writer_tb failed");
        $finish;
    end

    // Take result beats, stall at random, and hold off on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                mirror.check_result(rsp);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic tcw_in_t make_cmd(logic [1:0] m, logic [7:0] ch, logic [7:0] at,
                                         logic [6:0] cl, logic [4:0] rw);
        tcw_in_t c;
        c.mode      = m;
        c.char_code = ch;
        c.attr_in   = at;
        c.column    = cl;
        c.row       = rw;
        return c;
    endfunction

    // Offer one command beat after random gaps; hold it until taken
    task automatic send_cmd(input tcw_in_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        mirror.apply_command(c);
        sent_items++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_cmd(make_cmd(MODE_PUT, ch, 8'($urandom), 7'($urandom), 5'($urandom)));
    endtask

    task automatic peek(input logic [6:0] cl, input logic [4:0] rw);
        send_cmd(make_cmd(MODE_PEEK, 8'($urandom), 8'($urandom), cl, rw));
    endtask

    task automatic poke(input logic [7:0] ch, input logic [7:0] at,
                        input logic [6:0] cl, input logic [4:0] rw);
        send_cmd(make_cmd(MODE_POKE, ch, at, cl, rw));
    endtask

    // Drop valid and wait until every awaited result has arrived
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_colour(input logic idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mirror.set_colour(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_colours(input logic [3:0] f, input logic [3:0] b);
        drain_results();
        write_colour(REG_FG, f);
        write_colour(REG_BG, b);
    endtask

    task automatic newline_burst(input int len);
        int k;
        for (k = 0; k < len; k++)
            put_char(CH_NL);
    endtask

    task automatic tab_run(input int len);
        int k;
        for (k = 0; k < len; k++)
            put_char(CH_TAB);
    endtask

    // Random command sequences until the given number of beats has gone in
    task automatic run_random(input int count);
        int         goal;
        int         kind;
        int         len;
        int         k;
        int         pick;
        logic [7:0] ch;
        logic [6:0] cl;
        logic [4:0] rw;
        goal = sent_items + count;
        while (sent_items < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                send_cmd(make_cmd(2'($urandom), 8'($urandom), 8'($urandom),
                                  7'($urandom), 5'($urandom)));
            else if (kind < 62)
            begin
                // text with the odd control code mixed in
                len = $urandom_range(4, 20);
                for (k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        ch = 8'($urandom_range(32, 126));
                    else if (pick < 90)
                        ch = 8'($urandom);
                    else
                        case ($urandom_range(0, 3))
                            0:       ch = CH_NL;
                            1:       ch = CH_CR;
                            2:       ch = CH_TAB;
                            default: ch = CH_BS;
                        endcase
                    put_char(ch);
                end
            end
            else if (kind < 70)
                newline_burst($urandom_range(3, 15));
            else if (kind < 77)
                tab_run($urandom_range(2, 12));
            else if (kind < 90)
            begin
                // read back around the cursor line
                len = $urandom_range(2, 6);
                for (k = 0; k < len; k++)
                    peek(7'($urandom_range(0, COLUMNS - 1)),
                         ($urandom_range(0, 1) != 0) ? 5'(mirror.caret_row)
                                                     : 5'($urandom_range(0, ROWS - 1)));
            end
            else if (kind < 98)
            begin
                cl = 7'($urandom_range(0, COLUMNS - 1));
                rw = 5'($urandom_range(0, ROWS - 1));
                poke(8'($urandom), 8'($urandom), cl, rw);
                peek(cl, rw);
            end
            else
                send_cmd(make_cmd(MODE_CLEAR, 8'($urandom), 8'($urandom),
                                  7'($urandom), 5'($urandom)));
        end
    endtask

    initial
    begin
        int k;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FG;
        cfg_data      = 4'd0;
        hold_left     = 0;
        sent_items    = 0;
        send_idle_pct = 13;
        recv_idle_pct = 57;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, range edges, control codes, clear
        peek(7'd0, 5'd0);
        peek(7'(COLUMNS - 1), 5'(ROWS - 1));
        peek(7'(COLUMNS), 5'd0);
        peek(7'h7F, 5'h1F);
        poke(8'hFF, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1));
        peek(7'(COLUMNS - 1), 5'(ROWS - 1));
        poke(8'h11, 8'h00, 7'd0, 5'(ROWS));
        poke(8'h22, 8'h5A, 7'h7F, 5'd0);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BS);
        peek(7'd2, 5'd0);
        put_char(CH_CR);
        put_char(CH_BS);
        put_char(CH_TAB);
        put_char(CH_TAB);
        put_char(CH_NL);
        put_char(8'h7E);
        send_cmd(make_cmd(MODE_CLEAR, 8'h00, 8'h00, 7'h00, 5'h00));
        peek(7'(COLUMNS - 1), 5'(ROWS - 1));
        peek(7'd0, 5'(ROWS - 1));

        // Sender idles lightly, receiver idles heavily
        set_colours(4'hF, 4'hF);
        newline_burst(30);
        tab_run(12);
        run_random(150);
        set_colours(4'h0, 4'h0);
        run_random(90);

        // Sender idles heavily, receiver idles lightly
        send_idle_pct = 57;
        recv_idle_pct = 13;
        set_colours(4'hF, 4'h0);
        run_random(90);
        set_colours(4'h0, 4'hF);
        run_random(90);

        // No idling; hold results back long enough to back the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_colours(4'($urandom), 4'($urandom));
        hold_left = 400;
        for (k = 0; k < 40; k++)
            if ($urandom_range(0, 1) != 0)
                peek(7'($urandom_range(0, COLUMNS - 1)), 5'($urandom_range(0, ROWS - 1)));
            else
                poke(8'($urandom), 8'($urandom), 7'($urandom_range(0, COLUMNS - 1)),
                     5'($urandom_range(0, ROWS - 1)));
        run_random(60);
        set_colours(4'($urandom), 4'($urandom));
        run_random(90);

        // Wait out any straggling beat, then report
        drain_results();
        repeat (64) @(posedge clk);
        if (mirror.errors == 0)
            $display("text_console_writer_tb passed");
        else
            $display("text_console_writer_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_dp.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
